### rtl/peer_table_with_aging_unit_defines.svh
// Assertion macros shared by the peer table RTL.
`ifndef PEER_TABLE_WITH_AGING_UNIT_DEFINES_SVH
`define PEER_TABLE_WITH_AGING_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PTWA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising edge outside reset.
`define PTWA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### rtl/ptwa_pkg.sv
// Types, codes and constants shared by the peer table modules.
`default_nettype none

package ptwa_pkg;

  localparam int unsigned MaxEntriesDef = 8;
  localparam int unsigned MaxResults    = 28;
  localparam int unsigned CntW          = $clog2(MaxResults + 1);
  localparam logic [15:0] TimeoutReset  = 16'd300;

  typedef enum logic [1:0] {
    OP_JOIN  = 2'd0,
    OP_CHAT  = 2'd1,
    OP_TICK  = 2'd2,
    OP_SWEEP = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_WELCOME   = 3'd0,
    KIND_JOIN_NOTE = 3'd1,
    KIND_REJ_FULL  = 3'd2,
    KIND_RELAY     = 3'd3,
    KIND_REJ_NOJN  = 3'd4,
    KIND_LEAVE     = 3'd5
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  item_load;
    logic  tick;
    logic  scan_inc;
    logic  scan_clr;
    logic  free_upd;
    logic  slot_ld_scan;
    logic  slot_ld_free;
    logic  slot_inc;
    logic  table_write;
    logic  evict;
    logic  emit;
    logic  emit_entry;
    logic  about_zero;
    kind_e kind;
    logic  flush;
  } ptwa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic stall;
    logic pend_valid;
    logic hit;
    logic free_any;
    logic scan_last;
    logic slot_last;
    logic scan_emit;
    logic slot_expired;
  } ptwa_stat_t;

endpackage

`default_nettype wire

### rtl/peer_table_with_aging_unit.sv
// Top level of the peer table with aging: controller and datapath.
//
// Usage: commands enter on the slave stream. tuser carries the command (join, chat
// message, tick, sweep) and tdata the sender address and port. Results leave on the
// master stream: tuser carries the result kind, tdata the destination and the
// slot the result is about, and tlast marks the final result of an item.
// The block handles one item at a time and scans the table one entry per cycle while
// the receiver keeps up. A tick gives no result. A join runs a lookup scan, a table
// update, a welcome, a fan-out scan and a flush; a chat message runs the same steps
// without the welcome, and a rejected one a lookup scan, a reject result and a flush;
// a lookup that hits stops early. A sweep checks each slot in turn and runs a fan-out
// scan for each evicted peer. Results pass through a holding register and an output
// register; a result leaves the holding register only when the next result of the
// same item is ready or the item is flushed, so the first result waits there until
// then. When the receiver stalls, the holding register fills and the scan waits;
// nothing is dropped. At most 28 results are given per item.
// Reset clears all entries, the seconds counter and the output stage, and loads
// the timeout register with 300. The timeout may be written in any cycle the
// block is idle; there is no clearing pass.
`default_nettype none

module peer_table_with_aging_unit import ptwa_pkg::*; #(
  parameter int unsigned MaxEntries = MaxEntriesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,   // timeout_seconds
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // [31:0] src_ip, [47:32] src_port
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,  // [31:0] dest_ip, [47:32] dest_port,
                                          // [50:48] about_slot, rest zero
  output logic [2:0]       m_axis_tuser,  // [2:0] kind
  output logic             m_axis_tlast   // last
);

  ptwa_cmd_t  cmd;
  ptwa_stat_t stat;

  logic [31:0] out_ip;
  logic [15:0] out_port;
  logic [2:0]  out_about;

  ptwa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .op_i    (s_axis_tuser),
    .ready_o (s_axis_tready),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  ptwa_dp #(
    .MaxEntries (MaxEntries)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .src_ip_i    (s_axis_tdata[31:0]),
    .src_port_i  (s_axis_tdata[47:32]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_ip_o    (out_ip),
    .out_port_o  (out_port),
    .out_about_o (out_about),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b00000, out_about, out_port, out_ip};

endmodule

`default_nettype wire

### rtl/ptwa_ctrl.sv
// Controller state machine that sequences lookup, update, fan-out and sweep.
`default_nettype none
`include "peer_table_with_aging_unit_defines.svh"

module ptwa_ctrl import ptwa_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  wire logic [1:0] op_i,
  output logic            ready_o,
  input  wire ptwa_stat_t stat_i,
  output ptwa_cmd_t       cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_LOOK    = 8'b0000_0010,
    S_UPDATE  = 8'b0000_0100,
    S_WELCOME = 8'b0000_1000,
    S_REJECT  = 8'b0001_0000,
    S_FAN     = 8'b0010_0000,
    S_SWEEP   = 8'b0100_0000,
    S_FLUSH   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  op_e    op_in;
  kind_e  fan_kind;

  assign op_in   = op_e'(op_i);
  assign ready_o = (state_q == S_IDLE);

  always_comb begin
    unique case (op_q)
      OP_JOIN:  fan_kind = KIND_JOIN_NOTE;
      OP_CHAT:  fan_kind = KIND_RELAY;
      OP_TICK:  fan_kind = KIND_LEAVE;
      OP_SWEEP: fan_kind = KIND_LEAVE;
      default:  fan_kind = KIND_LEAVE;
    endcase
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '0;
    cmd_o.kind = KIND_WELCOME;
    unique case (state_q)
      S_IDLE: begin
        if (valid_i) begin
          cmd_o.item_load = 1'b1;
          op_d            = op_in;
          unique case (op_in)
            OP_JOIN, OP_CHAT: state_d = S_LOOK;
            OP_TICK: begin
              cmd_o.tick = 1'b1;
              state_d    = S_IDLE;
            end
            OP_SWEEP: state_d = S_SWEEP;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_LOOK: begin
        cmd_o.free_upd = 1'b1;
        if (stat_i.hit) begin
          cmd_o.slot_ld_scan = 1'b1;
          state_d            = S_UPDATE;
        end else if (stat_i.scan_last) begin
          if (op_q == OP_JOIN && stat_i.free_any) begin
            cmd_o.slot_ld_free = 1'b1;
            state_d            = S_UPDATE;
          end else begin
            state_d = S_REJECT;
          end
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      S_UPDATE: begin
        cmd_o.table_write = 1'b1;
        cmd_o.scan_clr    = 1'b1;
        state_d           = (op_q == OP_JOIN) ? S_WELCOME : S_FAN;
      end
      S_WELCOME: begin
        cmd_o.emit = 1'b1;
        cmd_o.kind = KIND_WELCOME;
        if (!stat_i.stall) begin
          state_d = S_FAN;
        end
      end
      S_REJECT: begin
        cmd_o.emit       = 1'b1;
        cmd_o.about_zero = 1'b1;
        cmd_o.kind       = (op_q == OP_JOIN) ? KIND_REJ_FULL : KIND_REJ_NOJN;
        if (!stat_i.stall) begin
          state_d = S_FLUSH;
        end
      end
      S_FAN: begin
        cmd_o.emit       = stat_i.scan_emit;
        cmd_o.emit_entry = 1'b1;
        cmd_o.kind       = fan_kind;
        if (!stat_i.stall) begin
          if (!stat_i.scan_last) begin
            cmd_o.scan_inc = 1'b1;
          end else if (op_q == OP_SWEEP && !stat_i.slot_last) begin
            cmd_o.slot_inc = 1'b1;
            state_d        = S_SWEEP;
          end else begin
            state_d = S_FLUSH;
          end
        end
      end
      S_SWEEP: begin
        if (stat_i.slot_expired) begin
          cmd_o.evict    = 1'b1;
          cmd_o.scan_clr = 1'b1;
          state_d        = S_FAN;
        end else if (stat_i.slot_last) begin
          state_d = S_FLUSH;
        end else begin
          cmd_o.slot_inc = 1'b1;
        end
      end
      S_FLUSH: begin
        cmd_o.flush = 1'b1;
        if (!stat_i.stall) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_JOIN;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // No result may linger in the holding stage once the block takes new items.
  `PTWA_ASSERT_IMPL(a_idle_no_pend, clk_i, rst_ni, state_q == S_IDLE, !stat_i.pend_valid)
  `PTWA_ASSERT_NEXT(a_tick_stays_idle, clk_i, rst_ni, valid_i && ready_o && op_in == OP_TICK, state_q == S_IDLE)
  `PTWA_ASSERT_NEXT(a_hit_updates, clk_i, rst_ni, state_q == S_LOOK && stat_i.hit, state_q == S_UPDATE)

endmodule

`default_nettype wire

### rtl/ptwa_dp.sv
// Datapath: peer table, clock and timeout registers, scan counters, result stages.
`default_nettype none
`include "peer_table_with_aging_unit_defines.svh"

module ptwa_dp import ptwa_pkg::*; #(
  parameter int unsigned MaxEntries = MaxEntriesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic [31:0] src_ip_i,
  input  wire logic [15:0] src_port_i,
  input  wire ptwa_cmd_t   cmd_i,
  output ptwa_stat_t       stat_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       out_kind_o,
  output logic [31:0]      out_ip_o,
  output logic [15:0]      out_port_o,
  output logic [2:0]       out_about_o,
  output logic             out_last_o
);

  localparam int unsigned IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MaxEntries - 1);

  typedef struct packed {
    kind_e       kind;
    logic [31:0] ip;
    logic [15:0] port;
    logic [2:0]  about;
  } res_t;

  // Table storage; valid bits are reset, the payload is written before use.
  logic [MaxEntries-1:0] valid_q, valid_d;
  logic [31:0] ip_q   [MaxEntries];
  logic [15:0] port_q [MaxEntries];
  logic [31:0] seen_q [MaxEntries];

  logic [31:0]     seconds_q;
  logic [15:0]     timeout_q;
  logic [31:0]     key_ip_q;
  logic [15:0]     key_port_q;
  logic [IdxW-1:0] scan_q, slot_q, free_q;
  logic            free_found_q;
  logic [CntW-1:0] cnt_q;

  res_t pend_q, out_q, res_new;
  logic pend_valid_q, out_valid_q, out_last_q;

  logic [IdxW+2:0] slot_ext;
  logic [31:0]     age;
  logic            expired;
  logic            cnt_full, emit_take, out_free, stall, move;

  assign slot_ext = {3'b000, slot_q};
  assign age      = seconds_q - seen_q[slot_q];
  assign expired  = age > {16'h0000, timeout_q};

  assign res_new.kind  = cmd_i.kind;
  assign res_new.ip    = cmd_i.emit_entry ? ip_q[scan_q] : key_ip_q;
  assign res_new.port  = cmd_i.emit_entry ? port_q[scan_q] : key_port_q;
  assign res_new.about = cmd_i.about_zero ? 3'b000 : slot_ext[2:0];

  // Results past the cap are dropped; the last one kept still carries the end mark.
  assign cnt_full  = (cnt_q == CntW'(MaxResults));
  assign emit_take = cmd_i.emit && !cnt_full;
  assign out_free  = !out_valid_q || out_ready_i;
  assign stall     = (emit_take || cmd_i.flush) && pend_valid_q && !out_free;
  assign move      = (emit_take || cmd_i.flush) && pend_valid_q && out_free;

  always_comb begin
    stat_o.stall        = stall;
    stat_o.pend_valid   = pend_valid_q;
    stat_o.hit          = valid_q[scan_q] && (ip_q[scan_q] == key_ip_q) &&
                          (port_q[scan_q] == key_port_q);
    stat_o.free_any     = free_found_q || !valid_q[scan_q];
    stat_o.scan_last    = (scan_q == LastIdx);
    stat_o.slot_last    = (slot_q == LastIdx);
    stat_o.scan_emit    = valid_q[scan_q] && (scan_q != slot_q);
    stat_o.slot_expired = valid_q[slot_q] && expired;
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.table_write) begin
      valid_d[slot_q] = 1'b1;
    end
    if (cmd_i.evict) begin
      valid_d[slot_q] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      seconds_q    <= '0;
      timeout_q    <= TimeoutReset;
      scan_q       <= '0;
      slot_q       <= '0;
      free_q       <= '0;
      free_found_q <= 1'b0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (cmd_i.tick) begin
        seconds_q <= seconds_q + 32'd1;
      end

      if (cmd_i.item_load || cmd_i.scan_clr) begin
        scan_q <= '0;
      end else if (cmd_i.scan_inc) begin
        scan_q <= scan_q + IdxW'(1);
      end

      if (cmd_i.item_load) begin
        slot_q <= '0;
      end else if (cmd_i.slot_ld_scan) begin
        slot_q <= scan_q;
      end else if (cmd_i.slot_ld_free) begin
        slot_q <= free_found_q ? free_q : scan_q;
      end else if (cmd_i.slot_inc) begin
        slot_q <= slot_q + IdxW'(1);
      end

      if (cmd_i.item_load) begin
        free_found_q <= 1'b0;
      end else if (cmd_i.free_upd && !valid_q[scan_q] && !free_found_q) begin
        free_found_q <= 1'b1;
        free_q       <= scan_q;
      end

      if (cmd_i.item_load) begin
        cnt_q <= '0;
      end else if (emit_take && !stall) begin
        cnt_q <= cnt_q + CntW'(1);
      end

      if (emit_take && !stall) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.flush && !stall) begin
        pend_valid_q <= 1'b0;
      end

      if (move) begin
        out_valid_q <= 1'b1;
        out_last_q  <= cmd_i.flush;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      key_ip_q   <= src_ip_i;
      key_port_q <= src_port_i;
    end
    if (cmd_i.table_write) begin
      ip_q[slot_q]   <= key_ip_q;
      port_q[slot_q] <= key_port_q;
      seen_q[slot_q] <= seconds_q;
    end
    if (emit_take && !stall) begin
      pend_q <= res_new;
    end
    if (move) begin
      out_q <= pend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_q.kind;
  assign out_ip_o    = out_q.ip;
  assign out_port_o  = out_q.port;
  assign out_about_o = out_q.about;
  assign out_last_o  = out_last_q;

  `PTWA_ASSERT_IMPL(a_stall_needs_busy_out, clk_i, rst_ni, stall, out_valid_q && !out_ready_i)
  `PTWA_ASSERT_IMPL(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(MaxResults))
  `PTWA_ASSERT_NEXT(a_flush_empties, clk_i, rst_ni, cmd_i.flush && !stall, !pend_valid_q)

endmodule

`default_nettype wire

### tb/peer_table_with_aging_unit_tb.sv
// Self-checking testbench for the peer table with aging: directed script, then random traffic.
module peer_table_with_aging_unit_tb import ptwa_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Table size of the instance under test and a few knobs of the run.
  localparam int unsigned Slots           = MaxEntriesDef;
  localparam int unsigned PoolSize        = 12;
  localparam int unsigned Segments        = 6;
  localparam int unsigned ItemsPerSegment = 53;
  // A sweep that evicts every peer runs a fan-out scan of the table for each eviction before
  // it goes quiet, so this many cycles without traffic is enough to call the block idle.
  localparam int unsigned SettleCycles    = 120;
  // The slowest correct run stays well below this even with the heaviest receiver stalls.
  localparam longint unsigned CycleLimit  = 1_000_000;

  // One delivery as it leaves the block.
  typedef struct packed {
    kind_e       kind;
    logic [31:0] ip;
    logic [15:0] port;
    logic [2:0]  slot;
    logic        last;
  } delivery_t;

  // A line of the directed script: either a command item or a timeout write. For a
  // timeout write the new value travels in the port field. Rows whose outcome is obvious
  // carry a typed single delivery back to the sender instead of the predicted one.
  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e   what;
    op_e         op;
    logic [31:0] ip;
    logic [15:0] port;
    logic        typed;
    kind_e       want_kind;
    logic [2:0]  want_slot;
  } script_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Mirror of the peer table, the seconds counter and the timeout register.
  logic        mirror_valid [Slots];
  logic [31:0] mirror_ip    [Slots];
  logic [15:0] mirror_port  [Slots];
  logic [31:0] mirror_seen  [Slots];
  logic [31:0] mirror_clock;
  logic [15:0] mirror_timeout;

  // Deliveries worked out for the item in hand, and all deliveries still owed by the block.
  delivery_t   step_out[$];
  delivery_t   deliveries_due[$];
  delivery_t   got_d;
  delivery_t   want_d;

  script_row_t script[$];
  logic [31:0] pool_ip   [PoolSize];
  logic [15:0] pool_port [PoolSize];

  int unsigned     mismatches;
  int unsigned     src_idle_pct;
  int unsigned     dst_idle_pct;
  longint unsigned cycles;

  peer_table_with_aging_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [31:0] src_ip, [47:32] src_port
    .s_axis_tuser  (s_axis_tuser),   // [1:0] cmd
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [31:0] dest_ip, [47:32] dest_port, [50:48] about_slot
    .m_axis_tuser  (m_axis_tuser),   // [2:0] kind
    .m_axis_tlast  (m_axis_tlast)    // last
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------------------
  // Predictor of the peer table.
  // ---------------------------------------------------------------------------------------

  // Adds one delivery to the item in hand; anything past the per-item cap is dropped.
  function automatic void queue_delivery(kind_e k, logic [31:0] ip, logic [15:0] port,
                                         int unsigned slot);
    delivery_t d;
    if (step_out.size() >= MaxResults) return;
    d.kind = k;
    d.ip   = ip;
    d.port = port;
    d.slot = 3'(slot);
    d.last = 1'b0;
    step_out.push_back(d);
  endfunction

  // One delivery of the given kind to every active peer except the one it is about,
  // in slot order.
  function automatic void notify_others(kind_e k, int about);
    for (int i = 0; i < Slots; i++)
      if (mirror_valid[i] && i != about)
        queue_delivery(k, mirror_ip[i], mirror_port[i], about);
  endfunction

  // Slot of the active peer with this address and port, or -1 when it is unknown.
  function automatic int find_peer(logic [31:0] ip, logic [15:0] port);
    for (int i = 0; i < Slots; i++)
      if (mirror_valid[i] && mirror_ip[i] == ip && mirror_port[i] == port)
        return i;
    return -1;
  endfunction

  // Applies one command item to the mirror and leaves its deliveries in step_out.
  function automatic void predict_peer_step(op_e op, logic [31:0] ip, logic [15:0] port);
    int slot;
    step_out.delete();
    case (op)
      OP_JOIN: begin
        slot = find_peer(ip, port);
        // A new peer takes the lowest free slot, if there is one.
        if (slot < 0) begin
          for (int i = 0; i < Slots; i++)
            if (!mirror_valid[i] && slot < 0) slot = i;
          if (slot >= 0) begin
            mirror_valid[slot] = 1'b1;
            mirror_ip[slot]    = ip;
            mirror_port[slot]  = port;
          end
        end
        if (slot < 0) begin
          queue_delivery(KIND_REJ_FULL, ip, port, 0);
        end else begin
          mirror_seen[slot] = mirror_clock;
          queue_delivery(KIND_WELCOME, ip, port, slot);
          notify_others(KIND_JOIN_NOTE, slot);
        end
      end
      OP_CHAT: begin
        slot = find_peer(ip, port);
        if (slot < 0) begin
          queue_delivery(KIND_REJ_NOJN, ip, port, 0);
        end else begin
          mirror_seen[slot] = mirror_clock;
          notify_others(KIND_RELAY, slot);
        end
      end
      OP_TICK: begin
        mirror_clock = mirror_clock + 32'd1;
      end
      default: begin
        // Ages are taken modulo 2^32 and must strictly exceed the timeout. Each eviction
        // is announced to the peers that are still in the table at that point.
        for (int i = 0; i < Slots; i++) begin
          if (mirror_valid[i] && (mirror_clock - mirror_seen[i]) > {16'd0, mirror_timeout}) begin
            mirror_valid[i] = 1'b0;
            mirror_ip[i]    = '0;
            mirror_port[i]  = '0;
            mirror_seen[i]  = '0;
            notify_others(KIND_LEAVE, i);
          end
        end
      end
    endcase
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus side. Every task starts and ends at a falling edge.
  // ---------------------------------------------------------------------------------------

  // Offers one command item, waits for it to be taken and records what it must cause.
  // A typed row replaces the predicted deliveries by its own, but still updates the mirror.
  task automatic push_cmd(op_e op, logic [31:0] ip, logic [15:0] port, logic typed,
                          delivery_t typed_result);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {port, ip};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_peer_step(op, ip, port);
    if (typed) begin
      deliveries_due.push_back(typed_result);
    end else begin
      foreach (step_out[i]) deliveries_due.push_back(step_out[i]);
    end
    @(negedge clk_i);
  endtask

  // Stops offering items and waits until the block owes nothing and has had time to
  // finish any scan that gives no delivery (ticks, quiet sweeps, lone evictions).
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (deliveries_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Writes the timeout register; only called while the block is idle.
  task automatic write_timeout(logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    mirror_timeout = value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // One random item. Most traffic uses a small pool of known keys so that joins, chats
  // and sweeps meet real table entries; the rest is noise with fresh keys.
  task automatic random_item();
    int          r;
    int          k;
    logic [31:0] ip;
    logic [15:0] port;
    k    = $urandom_range(PoolSize - 1);
    ip   = pool_ip[k];
    port = pool_port[k];
    r    = $urandom_range(99);
    if (r < 32)
      push_cmd(OP_JOIN, ip, port, 1'b0, '0);
    else if (r < 55)
      push_cmd(OP_CHAT, ip, port, 1'b0, '0);
    else if (r < 78)
      push_cmd(OP_TICK, $urandom, 16'($urandom), 1'b0, '0);
    else if (r < 90)
      push_cmd(OP_SWEEP, $urandom, 16'($urandom), 1'b0, '0);
    else if (r < 95)
      push_cmd(OP_JOIN, $urandom, 16'($urandom), 1'b0, '0);
    else
      push_cmd(OP_CHAT, $urandom, 16'($urandom), 1'b0, '0);
  endtask

  function automatic void add_row(row_kind_e what, op_e op, logic [31:0] ip,
                                  logic [15:0] port, logic typed = 1'b0,
                                  kind_e want_kind = KIND_WELCOME,
                                  logic [2:0] want_slot = 3'd0);
    script_row_t row;
    row.what      = what;
    row.op        = op;
    row.ip        = ip;
    row.port      = port;
    row.typed     = typed;
    row.want_kind = want_kind;
    row.want_slot = want_slot;
    script.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Receiver side: random back-pressure, and the check of every delivery taken.
  // ---------------------------------------------------------------------------------------

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_d.kind = kind_e'(m_axis_tuser);
      got_d.ip   = m_axis_tdata[31:0];
      got_d.port = m_axis_tdata[47:32];
      got_d.slot = m_axis_tdata[50:48];
      got_d.last = m_axis_tlast;
      if (deliveries_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: delivery with none due: kind=%0d ip=%h port=%h slot=%0d last=%0b",
                   $realtime, got_d.kind, got_d.ip, got_d.port, got_d.slot, got_d.last);
      end else begin
        want_d = deliveries_due.pop_front();
        if (got_d !== want_d) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: delivery differs: expected kind=%0d ip=%h port=%h slot=%0d last=%0b",
                     $realtime, want_d.kind, want_d.ip, want_d.port, want_d.slot, want_d.last);
            $display("%0t:                   actual   kind=%0d ip=%h port=%h slot=%0d last=%0b",
                     $realtime, got_d.kind, got_d.ip, got_d.port, got_d.slot, got_d.last);
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("peer_table_with_aging_unit: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------------------

  initial begin : main_sequence
    logic [31:0] ip_base   [PoolSize / 2];
    logic [15:0] port_base [3];
    logic [15:0] seg_timeout [Segments];
    delivery_t   typed_d;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    mismatches    = 0;
    cycles        = 0;
    src_idle_pct  = 12;
    dst_idle_pct  = 79;

    for (int i = 0; i < Slots; i++) begin
      mirror_valid[i] = 1'b0;
      mirror_ip[i]    = '0;
      mirror_port[i]  = '0;
      mirror_seen[i]  = '0;
    end
    mirror_clock   = '0;
    mirror_timeout = TimeoutReset;

    // Pool keys come in pairs that share an address and in groups of four that share a port,
    // so the lookup must match both halves of the key.
    foreach (ip_base[i]) ip_base[i] = $urandom;
    foreach (port_base[i]) port_base[i] = 16'($urandom);
    for (int k = 0; k < PoolSize; k++) begin
      pool_ip[k]   = ip_base[k / 2];
      pool_port[k] = port_base[k % 3];
    end

    // Directed script, starting from the reset timeout. The seconds counter is 1 while
    // the table fills, 3 when the timeout drops to one second.
    add_row(ROW_ITEM, OP_TICK,  32'h0000_0000, 16'h0000);
    // Sweep of an empty table.
    add_row(ROW_ITEM, OP_SWEEP, 32'hFFFF_FFFF, 16'hFFFF);
    // Chat from a sender that never joined.
    add_row(ROW_ITEM, OP_CHAT,  32'h0000_0000, 16'h0000, 1'b1, KIND_REJ_NOJN, 3'd0);
    // The first join lands in slot 0 and has nobody else to tell.
    add_row(ROW_ITEM, OP_JOIN,  32'hFFFF_FFFF, 16'hFFFF, 1'b1, KIND_WELCOME, 3'd0);
    // A lone peer chatting has nobody to relay to.
    add_row(ROW_ITEM, OP_CHAT,  32'hFFFF_FFFF, 16'hFFFF);
    add_row(ROW_ITEM, OP_JOIN,  32'h0000_0000, 16'h0000);
    add_row(ROW_ITEM, OP_JOIN,  32'hFFFF_FFFF, 16'h0000);
    add_row(ROW_ITEM, OP_JOIN,  32'h0000_0000, 16'hFFFF);
    // A second join of a known peer refreshes it in place.
    add_row(ROW_ITEM, OP_JOIN,  32'hFFFF_FFFF, 16'hFFFF);
    add_row(ROW_ITEM, OP_CHAT,  32'h0000_0000, 16'h0000);
    add_row(ROW_ITEM, OP_JOIN,  32'hA5A5_A5A5, 16'h5A5A);
    add_row(ROW_ITEM, OP_JOIN,  32'h5A5A_5A5A, 16'hA5A5);
    add_row(ROW_ITEM, OP_JOIN,  32'h1234_5678, 16'h9ABC);
    add_row(ROW_ITEM, OP_JOIN,  32'h8765_4321, 16'hCDEF);
    // The table is full now.
    add_row(ROW_ITEM, OP_JOIN,  32'hDEAD_BEEF, 16'hBEEF, 1'b1, KIND_REJ_FULL, 3'd0);
    add_row(ROW_ITEM, OP_CHAT,  32'hDEAD_BEEF, 16'hBEEF, 1'b1, KIND_REJ_NOJN, 3'd0);
    add_row(ROW_ITEM, OP_TICK,  32'h0000_0000, 16'h0000);
    add_row(ROW_ITEM, OP_TICK,  32'hFFFF_FFFF, 16'hFFFF);
    // Full table, nothing old enough yet.
    add_row(ROW_ITEM, OP_SWEEP, 32'h0000_0000, 16'h0000);
    // With a one second timeout every peer goes at once: the longest burst of leave notices.
    add_row(ROW_CFG,  OP_TICK,  32'h0000_0000, 16'd1);
    add_row(ROW_ITEM, OP_SWEEP, 32'h0000_0000, 16'h0000);
    add_row(ROW_ITEM, OP_JOIN,  32'h0000_0000, 16'h0000, 1'b1, KIND_WELCOME, 3'd0);
    // A zero timeout keeps only peers seen in the current second.
    add_row(ROW_CFG,  OP_TICK,  32'h0000_0000, 16'd0);
    add_row(ROW_ITEM, OP_SWEEP, 32'h0000_0000, 16'h0000);
    add_row(ROW_ITEM, OP_TICK,  32'h0000_0000, 16'h0000);
    // The lone remaining peer is evicted with nobody left to tell.
    add_row(ROW_ITEM, OP_SWEEP, 32'h0000_0000, 16'h0000);

    // Timeouts of the random segments, the extremes among them.
    seg_timeout[0] = 16'd2;
    seg_timeout[1] = 16'hFFFF;
    seg_timeout[2] = 16'd1;
    seg_timeout[3] = 16'd7;
    seg_timeout[4] = 16'd0;
    seg_timeout[5] = 16'd4;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (script[i]) begin
      if (script[i].what == ROW_CFG) begin
        settle();
        write_timeout(script[i].port);
      end else begin
        typed_d.kind = script[i].want_kind;
        typed_d.ip   = script[i].ip;
        typed_d.port = script[i].port;
        typed_d.slot = script[i].want_slot;
        typed_d.last = 1'b1;
        push_cmd(script[i].op, script[i].ip, script[i].port, script[i].typed, typed_d);
      end
    end

    // Random segments: the sender mostly busy and the receiver mostly stalled, then the
    // reverse, then both at full rate. Each segment starts with a new timeout.
    for (int seg = 0; seg < Segments; seg++) begin
      settle();
      if (seg < 2) begin
        src_idle_pct = 12;
        dst_idle_pct = 79;
      end else if (seg < 4) begin
        src_idle_pct = 79;
        dst_idle_pct = 12;
      end else begin
        src_idle_pct = 0;
        dst_idle_pct = 0;
      end
      write_timeout(seg_timeout[seg]);
      repeat (ItemsPerSegment) random_item();
    end

    settle();
    if (mismatches == 0 && deliveries_due.size() == 0) begin
      $display("peer_table_with_aging_unit: match");
    end else begin
      $display("peer_table_with_aging_unit: mismatch");
    end
    $finish;
  end

endmodule
